FILE: hdl/dst_pkg.sv
// Shared constants, types and helpers for the datagram session tracker.
package dst_pkg;

	localparam int unsigned MaxDatagram = 2048;
	localparam int unsigned CountW      = 12;
	localparam int unsigned WordW       = 16;

	localparam logic [CountW-1:0] CountSat  = {CountW{1'b1}};
	localparam logic [CountW-1:0] HeaderLen = CountW'(8);
	localparam logic [CountW-1:0] MaxLen    = CountW'(MaxDatagram);
	localparam logic [CountW-1:0] StatusMin = CountW'(34);
	localparam logic [CountW-1:0] SeqMin    = CountW'(20);
	localparam logic [CountW-1:0] HsLen     = CountW'(9);

	localparam logic [WordW-1:0] LenFlag = 16'h8000;
	localparam logic [WordW-1:0] SeqMask = 16'hfff8;

	// byte offsets of captured fields
	localparam logic [CountW-1:0] OffLen    = CountW'(0);
	localparam logic [CountW-1:0] OffSess   = CountW'(2);
	localparam logic [CountW-1:0] OffSeq    = CountW'(4);
	localparam logic [CountW-1:0] OffType   = CountW'(6);
	localparam logic [CountW-1:0] OffFirst  = CountW'(8);
	localparam logic [CountW-1:0] OffMedia  = CountW'(10);
	localparam logic [CountW-1:0] OffReply  = CountW'(18);
	localparam logic [CountW-1:0] OffPeerA  = CountW'(24);
	localparam logic [CountW-1:0] OffPeerB  = CountW'(26);
	localparam logic [CountW-1:0] OffExtra  = CountW'(32);

	// packet types
	localparam logic [7:0] TypeHandshake = 8'd0;
	localparam logic [7:0] TypeStatus    = 8'd1;
	localparam logic [7:0] TypeMedia     = 8'd2;
	localparam logic [7:0] TypeReply     = 8'd3;
	localparam logic [7:0] HsAcceptCode  = 8'd1;

	// configuration register indexes
	localparam logic RegSessionId     = 1'b0;
	localparam logic RegStartSequence = 1'b1;

	typedef struct packed {
		logic status;
		logic reply;
		logic media;
	} seen_t;

	// Place byte b in word w if pos addresses one of its two bytes.
	function automatic logic [WordW-1:0] put_word(
		input logic [WordW-1:0]  w,
		input logic [CountW-1:0] pos,
		input logic [CountW-1:0] off,
		input logic [7:0]        b
	);
		logic [WordW-1:0] r;
		r = w;
		if (pos == off) begin
			r[7:0] = b;
		end else if (pos == off + CountW'(1)) begin
			r[15:8] = b;
		end
		return r;
	endfunction

	// Serial-number advance: take value only if strictly ahead of old.
	function automatic logic [WordW-1:0] advance(
		input logic [WordW-1:0] old,
		input logic [WordW-1:0] value
	);
		logic [WordW-1:0] delta;
		delta = value - old;
		return ((delta != '0) && !delta[WordW-1]) ? value : old;
	endfunction

endpackage

FILE: hdl/datagram_session_tracker_core.sv
// Datagram session tracker: header check and session/sequence tracking, one byte per beat.
//
// Datagram bytes enter one per beat on the input channel; last_byte marks the final
// byte, and sent_sequence is sampled with it. Each byte sits in an input register while
// the field capture and, on the final byte, the full header, session, status and
// sequence checks are evaluated in a single short combinational pass; the result beat
// (one per datagram, none for other bytes) lands in an output register as the final
// byte leaves the input register. A new byte is taken every cycle; the only
// thing that holds the input back is a final byte finding the output register still
// occupied by a result the consumer has stalled. Writing session_id (index 0) restarts
// tracking: the peer position reloads from start_sequence with its low three bits
// cleared, media/reply counts and seen flags clear, and any partial datagram is
// dropped. start_sequence (index 1) is only stored. Write configuration only while no
// datagram is in flight. The byte counter saturates at 4095; a session_id of zero
// rejects everything.
module datagram_session_tracker_core
	import dst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [WordW-1:0]  wr_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [WordW-1:0]  sent_sequence,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic              handshake_ok,
	output logic [7:0]        packet_type,
	output logic [WordW-1:0]  peer_position,
	output logic [WordW-1:0]  media_count,
	output logic [WordW-1:0]  reply_count,
	output logic              status_seen
);

	// config registers
	logic [WordW-1:0] session_id_q, start_seq_q;

	// input stage
	logic             valid_s1, last_s1;
	logic [7:0]       byte_s1;
	logic [WordW-1:0] sent_s1;

	// capture state
	logic [CountW-1:0] count_q;
	logic [7:0]        hxor_q, type_q, first_q;
	logic [WordW-1:0]  len_q, sess_q, seq_q, media_w_q, reply_w_q;
	logic [WordW-1:0]  peer_a_q, peer_b_q, extra_q;

	// tracking state
	logic [WordW-1:0] peer_pos_q, media_rx_q, reply_rx_q;
	seen_t            seen_q;

	// output register
	logic out_valid_q;

	logic out_free, s1_go, in_take, restart;

	assign out_free = !out_valid_q || !out_stall;
	// a non-final byte never needs the output register
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;
	assign restart  = wr_en && (wr_index == RegSessionId);

	// ---- capture of the byte in stage 1 ----
	logic [CountW-1:0] pos, n;
	logic [7:0]        hxor_n, type_n, first_n;
	logic [WordW-1:0]  len_n, sess_n, seq_n, media_w_n, reply_w_n;
	logic [WordW-1:0]  peer_a_n, peer_b_n, extra_n;

	always_comb begin
		pos       = count_q;
		n         = (count_q == CountSat) ? count_q : count_q + CountW'(1);
		hxor_n    = (pos < HeaderLen) ? (hxor_q ^ byte_s1) : hxor_q;
		type_n    = (pos == OffType) ? byte_s1 : type_q;
		first_n   = (pos == OffFirst) ? byte_s1 : first_q;
		len_n     = put_word(len_q, pos, OffLen, byte_s1);
		sess_n    = put_word(sess_q, pos, OffSess, byte_s1);
		seq_n     = put_word(seq_q, pos, OffSeq, byte_s1);
		media_w_n = put_word(media_w_q, pos, OffMedia, byte_s1);
		reply_w_n = put_word(reply_w_q, pos, OffReply, byte_s1);
		peer_a_n  = put_word(peer_a_q, pos, OffPeerA, byte_s1);
		peer_b_n  = put_word(peer_b_q, pos, OffPeerB, byte_s1);
		extra_n   = put_word(extra_q, pos, OffExtra, byte_s1);
	end

	// ---- end-of-datagram checks ----
	logic             header_ok, sess_ok, hs, acc;
	logic [WordW-1:0] outstanding, seq_val;
	logic [WordW:0]   status_len;
	logic [WordW-1:0] peer_pos_n, media_rx_n, reply_rx_n;
	seen_t            seen_n;

	always_comb begin
		header_ok   = (n >= HeaderLen) && (n <= MaxLen) &&
		              (len_n == (LenFlag | WordW'(n))) && (hxor_n == '0);
		sess_ok     = header_ok && (session_id_q != '0) && (sess_n == session_id_q);
		hs          = sess_ok && (type_n == TypeHandshake) && (n == HsLen) &&
		              (first_n == HsAcceptCode);
		outstanding = sent_s1 - peer_b_n;
		status_len  = (WordW+1)'(StatusMin) + {1'b0, extra_n};
		seq_val     = seq_n & SeqMask;
		acc         = 1'b0;
		peer_pos_n  = peer_pos_q;
		media_rx_n  = media_rx_q;
		reply_rx_n  = reply_rx_q;
		seen_n      = seen_q;
		if (sess_ok) begin
			// handshake and unknown types fall through with no tracking update
			if (type_n == TypeStatus) begin
				if ((n >= StatusMin) && ((WordW+1)'(n) == status_len) &&
				    (peer_a_n == peer_b_n) && !outstanding[WordW-1] &&
				    (outstanding[2:0] == '0)) begin
					peer_pos_n = advance(peer_pos_q, peer_b_n);
					if (!seen_q.media) media_rx_n = media_w_n;
					if (!seen_q.reply) reply_rx_n = reply_w_n;
					seen_n.status = 1'b1;
					acc = 1'b1;
				end
			end else if (type_n == TypeMedia) begin
				if (n >= SeqMin) begin
					media_rx_n   = seen_q.media ? advance(media_rx_q, seq_val) : seq_val;
					seen_n.media = 1'b1;
					acc = 1'b1;
				end
			end else if (type_n == TypeReply) begin
				if (n >= SeqMin) begin
					reply_rx_n   = seen_q.reply ? advance(reply_rx_q, seq_val) : seq_val;
					seen_n.reply = 1'b1;
					acc = 1'b1;
				end
			end
		end
	end

	// ---- config registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_id_q <= '0;
			start_seq_q  <= '0;
		end else if (wr_en) begin
			if (wr_index == RegSessionId) session_id_q <= wr_data;
			else start_seq_q <= wr_data;
		end
	end

	// ---- input stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
			sent_s1 <= sent_sequence;
		end
	end

	// ---- capture and tracking state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			hxor_q     <= '0;
			type_q     <= '0;
			first_q    <= '0;
			len_q      <= '0;
			sess_q     <= '0;
			seq_q      <= '0;
			media_w_q  <= '0;
			reply_w_q  <= '0;
			peer_a_q   <= '0;
			peer_b_q   <= '0;
			extra_q    <= '0;
			peer_pos_q <= '0;
			media_rx_q <= '0;
			reply_rx_q <= '0;
			seen_q     <= '0;
		end else if (restart) begin
			count_q    <= '0;
			hxor_q     <= '0;
			type_q     <= '0;
			first_q    <= '0;
			len_q      <= '0;
			sess_q     <= '0;
			seq_q      <= '0;
			media_w_q  <= '0;
			reply_w_q  <= '0;
			peer_a_q   <= '0;
			peer_b_q   <= '0;
			extra_q    <= '0;
			peer_pos_q <= start_seq_q & SeqMask;
			media_rx_q <= '0;
			reply_rx_q <= '0;
			seen_q     <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				// datagram done: commit tracking, clear capture
				count_q    <= '0;
				hxor_q     <= '0;
				type_q     <= '0;
				first_q    <= '0;
				len_q      <= '0;
				sess_q     <= '0;
				seq_q      <= '0;
				media_w_q  <= '0;
				reply_w_q  <= '0;
				peer_a_q   <= '0;
				peer_b_q   <= '0;
				extra_q    <= '0;
				peer_pos_q <= peer_pos_n;
				media_rx_q <= media_rx_n;
				reply_rx_q <= reply_rx_n;
				seen_q     <= seen_n;
			end else begin
				count_q   <= n;
				hxor_q    <= hxor_n;
				type_q    <= type_n;
				first_q   <= first_n;
				len_q     <= len_n;
				sess_q    <= sess_n;
				seq_q     <= seq_n;
				media_w_q <= media_w_n;
				reply_w_q <= reply_w_n;
				peer_a_q  <= peer_a_n;
				peer_b_q  <= peer_b_n;
				extra_q   <= extra_n;
			end
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			accepted      <= acc;
			handshake_ok  <= hs;
			packet_type   <= header_ok ? type_n : '0;
			peer_position <= peer_pos_n;
			media_count   <= media_rx_n;
			reply_count   <= reply_rx_n;
			status_seen   <= seen_n.status;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: tb/sv/tb_datagram_session_tracker_core.sv
// Self-checking testbench for the datagram session tracker core.
module tb_datagram_session_tracker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dst_pkg::*;

	// Run guard and drain allowance.
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 8;

	// Kinds of directed/random steps: datagram flavors and the two register writes.
	typedef enum logic [2:0] {
		DG_GOOD,
		DG_BAD_XOR,
		DG_BAD_LEN,
		DG_PARTIAL,
		SET_SESSION,
		SET_START
	} step_t;

	// One datagram (or register write) to play. For writes, sess holds the data.
	typedef struct {
		step_t       kind;
		int          len;
		logic [7:0]  ptype;
		logic [15:0] sess;
		logic [15:0] seq;
		logic [7:0]  first;
		logic [15:0] peer_a;
		logic [15:0] peer_b;
		logic [15:0] extra;
		logic [15:0] sent;
		bit          typed;   // acc/hs/type below are typed in by hand
		bit          e_acc;
		bit          e_hs;
		logic [7:0]  e_type;
	} plan_t;

	// Expected result beat.
	typedef struct {
		logic        acc;
		logic        hs;
		logic [7:0]  ptype;
		logic [15:0] peer;
		logic [15:0] media;
		logic [15:0] reply;
		logic        status;
	} verdict_t;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic              wr_index;
	logic [WordW-1:0]  wr_data;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic [WordW-1:0]  sent_sequence;
	logic              out_valid;
	logic              out_stall;
	logic              accepted;
	logic              handshake_ok;
	logic [7:0]        packet_type;
	logic [WordW-1:0]  peer_position;
	logic [WordW-1:0]  media_count;
	logic [WordW-1:0]  reply_count;
	logic              status_seen;

	datagram_session_tracker_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.sent_sequence (sent_sequence),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.handshake_ok  (handshake_ok),
		.packet_type   (packet_type),
		.peer_position (peer_position),
		.media_count   (media_count),
		.reply_count   (reply_count),
		.status_seen   (status_seen)
	);

	// ------------------------------------------------------------------
	// Predictor state: configuration, per-datagram capture, tracking regs
	// ------------------------------------------------------------------
	logic [15:0]       cfg_session;
	logic [15:0]       cfg_start;
	logic [CountW-1:0] rx_count;
	logic [7:0]        rx_xor;
	logic [15:0]       w_len, w_sess, w_seq, w_media, w_reply;
	logic [15:0]       w_peer_a, w_peer_b, w_extra;
	logic [7:0]        w_type, w_first;
	logic [15:0]       trk_peer, trk_media, trk_reply;
	seen_t             trk_seen;

	verdict_t          verdict_q[$];   // results still owed by the block
	int                fault_cnt = 0;
	int                cycle_cnt = 0;

	// knobs shared with the idling processes
	int                send_idle_pct = 36;
	int                recv_stall_pct = 36;
	bit                hold_req = 0;

	function automatic void clear_capture();
		rx_count = '0;
		rx_xor = '0;
		w_len = '0; w_sess = '0; w_seq = '0; w_type = '0; w_first = '0;
		w_media = '0; w_reply = '0; w_peer_a = '0; w_peer_b = '0; w_extra = '0;
	endfunction

	// Session write: reload peer position from the seed, forget counts and flags.
	function automatic void restart_tracking();
		clear_capture();
		trk_peer = cfg_start & SeqMask;
		trk_media = '0;
		trk_reply = '0;
		trk_seen = '0;
	endfunction

	// Serial-number order: move only when value is strictly ahead by less than half range.
	function automatic logic [15:0] serial_ahead(input logic [15:0] cur, input logic [15:0] value);
		logic [15:0] gap;
		gap = value - cur;
		return (gap != 16'h0000 && gap < 16'h8000) ? value : cur;
	endfunction

	// Feed one byte; returns 1 with the expected beat when the byte closes a datagram.
	function automatic bit track_byte(input logic [7:0] b, input logic fin,
			input logic [15:0] sent, output verdict_t v);
		int          n;
		bit          hdr_ok;
		bit          sess_ok;
		logic [15:0] gap;
		logic [15:0] val;
		if (rx_count < HeaderLen)
			rx_xor ^= b;
		case (rx_count)
			OffLen:            w_len[7:0] = b;
			OffLen + 12'd1:    w_len[15:8] = b;
			OffSess:           w_sess[7:0] = b;
			OffSess + 12'd1:   w_sess[15:8] = b;
			OffSeq:            w_seq[7:0] = b;
			OffSeq + 12'd1:    w_seq[15:8] = b;
			OffType:           w_type = b;
			OffFirst:          w_first = b;
			OffMedia:          w_media[7:0] = b;
			OffMedia + 12'd1:  w_media[15:8] = b;
			OffReply:          w_reply[7:0] = b;
			OffReply + 12'd1:  w_reply[15:8] = b;
			OffPeerA:          w_peer_a[7:0] = b;
			OffPeerA + 12'd1:  w_peer_a[15:8] = b;
			OffPeerB:          w_peer_b[7:0] = b;
			OffPeerB + 12'd1:  w_peer_b[15:8] = b;
			OffExtra:          w_extra[7:0] = b;
			OffExtra + 12'd1:  w_extra[15:8] = b;
			default: ;
		endcase
		// counter sticks at all-ones; longer datagrams are judged at that size
		if (rx_count != CountSat)
			rx_count++;
		if (!fin)
			return 0;

		n = int'(rx_count);
		hdr_ok = n >= int'(HeaderLen) && n <= int'(MaxDatagram) &&
			w_len == (LenFlag | 16'(n)) && rx_xor == 8'h00;
		sess_ok = hdr_ok && cfg_session != 16'h0000 && w_sess == cfg_session;
		v.acc = 1'b0;
		v.hs = 1'b0;

		if (sess_ok) begin
			v.hs = w_type == TypeHandshake && n == int'(HsLen) && w_first == HsAcceptCode;
			if (w_type == TypeStatus) begin
				if (n >= int'(StatusMin) && n == int'(StatusMin) + int'(w_extra) &&
						w_peer_a == w_peer_b) begin
					// peer must sit at or behind the last sent frame, on a frame boundary
					gap = sent - w_peer_b;
					if (gap < 16'h8000 && gap[2:0] == 3'd0) begin
						trk_peer = serial_ahead(trk_peer, w_peer_b);
						if (!trk_seen.media)
							trk_media = w_media;
						if (!trk_seen.reply)
							trk_reply = w_reply;
						trk_seen.status = 1'b1;
						v.acc = 1'b1;
					end
				end
			end else if (w_type == TypeMedia || w_type == TypeReply) begin
				if (n >= int'(SeqMin)) begin
					val = w_seq & SeqMask;
					if (w_type == TypeMedia) begin
						trk_media = trk_seen.media ? serial_ahead(trk_media, val) : val;
						trk_seen.media = 1'b1;
					end else begin
						trk_reply = trk_seen.reply ? serial_ahead(trk_reply, val) : val;
						trk_seen.reply = 1'b1;
					end
					v.acc = 1'b1;
				end
			end
		end

		v.ptype = hdr_ok ? w_type : 8'h00;
		v.peer = trk_peer;
		v.media = trk_media;
		v.reply = trk_reply;
		v.status = trk_seen.status;
		clear_capture();
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// Datagram builder
	// ------------------------------------------------------------------
	function automatic void put16(ref logic [7:0] pkt[$], input int off, input logic [15:0] w);
		if (off < pkt.size())
			pkt[off] = w[7:0];
		if (off + 1 < pkt.size())
			pkt[off + 1] = w[15:8];
	endfunction

	// Random body, header and tracked words placed at their offsets, byte 7 balances the XOR.
	function automatic void build_dgram(input plan_t p, output logic [7:0] pkt[$]);
		logic [7:0]  x;
		logic [15:0] lw;
		pkt = {};
		for (int i = 0; i < p.len; i++)
			pkt.push_back(8'($urandom));
		if (p.len >= 8) begin
			lw = LenFlag | 16'(p.len);
			if (p.kind == DG_BAD_LEN)
				lw = $urandom_range(1) ? (lw ^ LenFlag) : (lw + 16'd1);
			put16(pkt, int'(OffLen), lw);
			put16(pkt, int'(OffSess), p.sess);
			put16(pkt, int'(OffSeq), p.seq);
			pkt[OffType] = p.ptype;
			if (p.len > int'(OffFirst))
				pkt[OffFirst] = p.first;
			put16(pkt, int'(OffPeerA), p.peer_a);
			put16(pkt, int'(OffPeerB), p.peer_b);
			put16(pkt, int'(OffExtra), p.extra);
			x = 8'h00;
			for (int i = 0; i < 7; i++)
				x ^= pkt[i];
			pkt[7] = x;
			if (p.kind == DG_BAD_XOR)
				pkt[7] ^= 8'(1 << $urandom_range(7));
		end
	endfunction

	// Mostly well-formed datagrams aimed near the tracked positions, plus noise.
	function automatic plan_t random_plan();
		plan_t       p;
		int unsigned sel;
		logic [15:0] base;
		p.kind = DG_GOOD;
		p.len = 20;
		p.ptype = TypeMedia;
		p.sess = cfg_session;
		p.seq = 16'($urandom);
		p.first = 8'($urandom);
		p.peer_a = 16'($urandom);
		p.peer_b = 16'($urandom);
		p.extra = 16'($urandom);
		p.sent = 16'($urandom);
		p.typed = 0;
		p.e_acc = 0;
		p.e_hs = 0;
		p.e_type = 8'h00;
		sel = $urandom_range(99);
		if (sel < 12) begin
			p.ptype = TypeHandshake;
			p.len = ($urandom_range(3) == 0) ? 8 + $urandom_range(3) : int'(HsLen);
			if ($urandom_range(4) != 0)
				p.first = HsAcceptCode;
		end else if (sel < 42) begin
			p.ptype = $urandom_range(1) ? TypeMedia : TypeReply;
			p.len = ($urandom_range(9) == 0) ? 8 + $urandom_range(11) : 20 + $urandom_range(8);
			base = (p.ptype == TypeMedia) ? trk_media : trk_reply;
			if ($urandom_range(3) != 0)
				p.seq = base + 16'(8 * (int'($urandom_range(10)) - 4)) +
					16'($urandom_range(7));
		end else if (sel < 72) begin
			p.ptype = TypeStatus;
			p.len = ($urandom_range(19) == 0) ? 20 + $urandom_range(13) : 34 + $urandom_range(6);
			p.extra = ($urandom_range(7) == 0) ? 16'($urandom_range(7)) : 16'(p.len - 34);
			if ($urandom_range(4) != 0)
				p.peer_a = trk_peer + 16'(8 * (int'($urandom_range(8)) - 2));
			if ($urandom_range(9) != 0)
				p.peer_b = p.peer_a;
			if ($urandom_range(6) != 0)
				p.sent = p.peer_b + 16'(8 * $urandom_range(4));
		end else if (sel < 80) begin
			p.ptype = 8'($urandom_range(255, 4));
			p.len = 9 + $urandom_range(31);
		end else if (sel < 88) begin
			p.kind = $urandom_range(1) ? DG_BAD_XOR : DG_BAD_LEN;
			p.ptype = 8'($urandom_range(3));
			p.len = 9 + $urandom_range(31);
		end else if (sel < 94) begin
			p.sess = cfg_session ^ 16'($urandom_range(65535, 1));
			p.ptype = 8'($urandom_range(3));
			p.len = 20 + $urandom_range(20);
		end else begin
			p.len = 1 + $urandom_range(6);
		end
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Directed table. Expected acc/hs/type typed in where obvious; rest predicted.
	// Columns: kind, len, type, sess/data, seq, byte8, peerA, peerB, extra, sent,
	//          typed, acc, hs, type
	// ------------------------------------------------------------------
	plan_t dir_plan[] = '{
		// session still zero after reset: header fine, nothing accepted
		'{DG_GOOD, 20, TypeMedia, 'h0000, 'h1234, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, TypeMedia},
		'{SET_START, 0, 'h00, 'h0ff8, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		'{SET_SESSION, 0, 'h00, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		// handshake reply and its near misses
		'{DG_GOOD, 9, TypeHandshake, 'h5a3c, 'h0, 'h01, 'h0, 'h0, 'h0, 'h0,
			1, 0, 1, TypeHandshake},
		'{DG_GOOD, 9, TypeHandshake, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0,
			1, 0, 0, TypeHandshake},
		'{DG_GOOD, 8, TypeHandshake, 'h5a3c, 'h0, 'h01, 'h0, 'h0, 'h0, 'h0,
			1, 0, 0, TypeHandshake},
		// header failures: too short, bad XOR, bad length word; also a bare header, a foreign session, a short reply
		'{DG_GOOD, 7, TypeMedia, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, 'h00},
		'{DG_GOOD, 8, TypeMedia, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, TypeMedia},
		'{DG_BAD_XOR, 20, TypeMedia, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, 'h00},
		'{DG_BAD_LEN, 20, TypeMedia, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, 'h00},
		'{DG_GOOD, 20, TypeMedia, 'h5a3d, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, TypeMedia},
		'{DG_GOOD, 19, TypeReply, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, TypeReply},
		// media/reply latch, wrap-around advance, half-range no-move
		'{DG_GOOD, 20, TypeMedia, 'h5a3c, 'hffff, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		'{DG_GOOD, 20, TypeReply, 'h5a3c, 'h0007, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		'{DG_GOOD, 24, TypeMedia, 'h5a3c, 'h0010, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		'{DG_GOOD, 20, TypeReply, 'h5a3c, 'h8000, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		// status: good, misaligned outstanding, split peers, bad extra, too short; then an unknown type
		'{DG_GOOD, 34, TypeStatus, 'h5a3c, 'h0, 'h00, 'h1000, 'h1000, 'd0, 'h1008,
			0, 0, 0, 'h00},
		'{DG_GOOD, 40, TypeStatus, 'h5a3c, 'h0, 'h00, 'h1010, 'h1010, 'd6, 'h1013,
			1, 0, 0, TypeStatus},
		'{DG_GOOD, 34, TypeStatus, 'h5a3c, 'h0, 'h00, 'h1010, 'h1018, 'd0, 'h1018,
			1, 0, 0, TypeStatus},
		'{DG_GOOD, 34, TypeStatus, 'h5a3c, 'h0, 'h00, 'h1010, 'h1010, 'd1, 'h1010,
			1, 0, 0, TypeStatus},
		'{DG_GOOD, 33, TypeStatus, 'h5a3c, 'h0, 'h00, 'h1010, 'h1010, 'd0, 'h1010,
			1, 0, 0, TypeStatus},
		'{DG_GOOD, 20, 'hff, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, 'hff},
		// status with the peer behind: accepted, position holds
		'{DG_GOOD, 34, TypeStatus, 'h5a3c, 'h0, 'h00, 'h0ff0, 'h0ff0, 'd0, 'h0ff0,
			0, 0, 0, 'h00},
		// half a datagram, then restart throws it away
		'{DG_PARTIAL, 12, TypeMedia, 'h5a3c, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		'{SET_SESSION, 0, 'h00, 'hffff, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		'{DG_GOOD, 20, TypeMedia, 'hffff, 'h4321, 'h00, 'h0, 'h0, 'h0, 'h0, 0, 0, 0, 'h00},
		// size extremes: largest legal, one over, past counter saturation
		'{DG_GOOD, 2048, TypeStatus, 'hffff, 'h0, 'h00, 'h2000, 'h2000, 'd2014, 'h2008,
			0, 0, 0, 'h00},
		'{DG_GOOD, 2049, TypeMedia, 'hffff, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, 'h00},
		'{DG_GOOD, 4100, TypeMedia, 'hffff, 'h0, 'h00, 'h0, 'h0, 'h0, 'h0, 1, 0, 0, 'h00}
	};

	// ------------------------------------------------------------------
	// Clock, cycle counter, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		while (cycle_cnt < CycleLimit)
			@(posedge clk);
		$display("FAIL datagram_session_tracker_core");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver side: random stall, plus a long hold-off on request so the
	// block backs up and stalls its input.
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 150;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every result beat against the oldest expectation
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fault_cnt++;
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (verdict_q.size() == 0) begin
				$error("result beat with no datagram pending");
				fault_cnt++;
			end else begin
				want = verdict_q.pop_front();
				check_field("accepted", 16'(want.acc), 16'(accepted));
				check_field("handshake_ok", 16'(want.hs), 16'(handshake_ok));
				check_field("packet_type", 16'(want.ptype), 16'(packet_type));
				check_field("peer_position", want.peer, peer_position);
				check_field("media_count", want.media, media_count);
				check_field("reply_count", want.reply, reply_count);
				check_field("status_seen", 16'(want.status), 16'(status_seen));
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offer one byte at the falling edge, after a random gap; hold until taken.
	task automatic drive_beat(input logic [7:0] b, input logic fin, input logic [15:0] sent);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		last_byte = fin;
		sent_sequence = sent;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering, let every owed result drain, then allow for in-flight bytes.
	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		quiesce();
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val;
		@(negedge clk);
		wr_en = 1'b0;
		if (idx == RegSessionId) begin
			cfg_session = val;
			restart_tracking();
		end else begin
			cfg_start = val;
		end
	endtask

	task automatic run_plan(input plan_t p);
		logic [7:0]  pkt[$];
		verdict_t    v;
		logic        fin;
		logic [15:0] snt;
		case (p.kind)
			SET_SESSION: write_reg(RegSessionId, p.sess);
			SET_START:   write_reg(RegStartSequence, p.sess);
			default: begin
				build_dgram(p, pkt);
				foreach (pkt[i]) begin
					fin = (i == pkt.size() - 1) && (p.kind != DG_PARTIAL);
					// sent sequence only matters on the final byte
					snt = fin ? p.sent : 16'($urandom);
					drive_beat(pkt[i], fin, snt);
					if (track_byte(pkt[i], fin, snt, v)) begin
						if (p.typed) begin
							v.acc = p.e_acc;
							v.hs = p.e_hs;
							v.ptype = p.e_type;
						end
						verdict_q.push_back(v);
					end
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		plan_t       p;
		logic [15:0] seed;
		logic [15:0] sess;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = 1'b0;
		wr_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		sent_sequence = '0;

		cfg_session = '0;
		cfg_start = '0;
		restart_tracking();

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_plan[i])
			run_plan(dir_plan[i]);

		// Random phases, each under fresh register settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin seed = 16'hfff8; sess = 16'hffff; end
				1: begin seed = 16'h0000; sess = 16'h0001; end
				default: begin
					seed = 16'($urandom) & SeqMask;
					sess = 16'($urandom_range(65535, 1));
				end
			endcase
			write_reg(RegStartSequence, seed);
			write_reg(RegSessionId, sess);

			// phase 2 runs with no idling on either side
			send_idle_pct = (ph == 2) ? 0 : 36;
			recv_stall_pct = (ph == 2) ? 0 : 36;

			if (ph == 3) begin
				// back-to-back short datagrams against a long receiver hold-off,
				// then wait for every owed result before going on
				send_idle_pct = 0;
				hold_req = 1;
				repeat (16) begin
					p = random_plan();
					p.kind = DG_GOOD;
					p.ptype = TypeHandshake;
					p.len = int'(HsLen);
					p.first = HsAcceptCode;
					p.sess = cfg_session;
					run_plan(p);
				end
				quiesce();
				send_idle_pct = 36;
			end

			repeat (8) run_plan(random_plan());
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fault_cnt == 0)
			$display("PASS datagram_session_tracker_core");
		else
			$display("FAIL datagram_session_tracker_core");
		$finish;
	end

endmodule
